// ----- src/supply_voltage_current_monitor_core_macros.svh -----
// ============================================================================
// Assertion macros for the supply monitor
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ============================================================================
`ifndef SUPPLY_VOLTAGE_CURRENT_MONITOR_CORE_MACROS_SVH
`define SUPPLY_VOLTAGE_CURRENT_MONITOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at each rising clock edge outside reset.
`define SVCM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked at each rising clock edge outside reset.
`define SVCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SVCM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SVCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- src/svcm_pkg.sv -----
// ============================================================================
// Supply monitor package
// Shared types, operation codes, register indexes and scaling constants.
// ============================================================================
package svcm_pkg;

   localparam int SAMPLE_W = 10;
   localparam int CODE_W   = 8;

   // Calibration averages 2**CAL_LOG2 current samples.
   localparam int CAL_LOG2  = 4;
   localparam int CAL_SUM_W = SAMPLE_W + CAL_LOG2;

   localparam logic [SAMPLE_W-1:0] FILTER_RESET  = SAMPLE_W'(512);
   localparam logic [SAMPLE_W-1:0] OFFSET_UNSET  = SAMPLE_W'(0);
   localparam logic [SAMPLE_W-1:0] OFFSET_DFLT   = SAMPLE_W'(512);

   localparam logic [SAMPLE_W-1:0] OVL_RESET = SAMPLE_W'(1000);
   localparam logic [SAMPLE_W-1:0] UVL_RESET = SAMPLE_W'(100);
   localparam logic [CODE_W-1:0]   OCL_RESET = CODE_W'(200);

   // Voltage path: clamp, halve, times 126/3 (exact), drop six bits.
   localparam logic [SAMPLE_W-1:0] VOLT_CLAMP = SAMPLE_W'(922);
   localparam int                  VOLT_MUL   = 126 / 3;

   // Current path: clamp, then times 125/427 by a reciprocal multiply.
   localparam logic [SAMPLE_W-2:0] CUR_CLAMP     = 9'(409);
   localparam int                  CUR_SHIFT     = 25;
   localparam int                  CUR_RECIP     = ((2 ** CUR_SHIFT) + 426) / 427;
   localparam logic [31:0]         CUR_MUL       = 32'(125 * CUR_RECIP);

   typedef enum logic [1:0] {
      OP_FILTER    = 2'd0,
      OP_CALIBRATE = 2'd1,
      OP_UPDATE    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_OVER_VOLTAGE  = 2'd0,
      CSR_UNDER_VOLTAGE = 2'd1,
      CSR_OVER_CURRENT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] over_voltage_limit;
      logic [SAMPLE_W-1:0] under_voltage_limit;
      logic [CODE_W-1:0]   over_current_limit;
   } limits_type;

   typedef struct packed {
      logic [CODE_W-1:0] scaled_voltage;
      logic [CODE_W-1:0] scaled_current;
      logic              over_voltage;
      logic              under_voltage;
      logic              over_current;
   } result_type;

endpackage

// ----- src/svcm_if.sv -----
// ============================================================================
// Supply monitor channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ============================================================================
interface svcm_req_if import svcm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [SAMPLE_W-1:0] current_sample;
   logic [SAMPLE_W-1:0] voltage_sample;

   modport source (output valid, op, current_sample, voltage_sample, input ready);
   modport sink   (input valid, op, current_sample, voltage_sample, output ready);
endinterface

interface svcm_rsp_if import svcm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] scaled_voltage;
   logic [CODE_W-1:0] scaled_current;
   logic              over_voltage;
   logic              under_voltage;
   logic              over_current;

   modport source (output valid, scaled_voltage, scaled_current, over_voltage,
                   under_voltage, over_current, input ready);
   modport sink   (input valid, scaled_voltage, scaled_current, over_voltage,
                   under_voltage, over_current, output ready);
endinterface

interface svcm_csr_if import svcm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          index;
   logic [SAMPLE_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/svcm_scale.sv -----
// ============================================================================
// Supply monitor scaling datapath
// Converts a voltage sample and the filtered current to 8-bit codes and flags.
// ============================================================================
module svcm_scale
   import svcm_pkg::*;
(
   input  logic [SAMPLE_W-1:0] voltage_sample,
   input  logic [SAMPLE_W-1:0] filtered_current,
   input  logic [SAMPLE_W-1:0] current_offset,
   input  limits_type          limits,
   output result_type          result
);

   logic [SAMPLE_W-1:0] volt_clamped;
   logic [SAMPLE_W-2:0] volt_half;
   logic [14:0]         volt_prod;
   logic [8:0]          volt_code;

   logic [SAMPLE_W-1:0] offset_eff;
   logic [SAMPLE_W-1:0] cur_diff;
   logic [SAMPLE_W-2:0] cur_clamped;
   logic [31:0]         cur_prod;
   logic [CODE_W-1:0]   cur_code;

   // Voltage: result of the multiply reaches 302 at most, so saturate to 255.
   always_comb begin
      volt_clamped = (voltage_sample > VOLT_CLAMP) ? VOLT_CLAMP : voltage_sample;
      volt_half    = volt_clamped[SAMPLE_W-1:1];
      volt_prod    = 15'(volt_half) * 15'(VOLT_MUL);
      volt_code    = volt_prod[14:6];
   end

   // Current: distance from the offset, clamped, scaled by 125/427.
   // The quotient never exceeds 119, so no saturation is needed.
   always_comb begin
      offset_eff = (current_offset == OFFSET_UNSET) ? OFFSET_DFLT : current_offset;
      cur_diff   = (filtered_current >= offset_eff) ? filtered_current - offset_eff
                                                    : offset_eff - filtered_current;
      cur_clamped = (cur_diff > SAMPLE_W'(CUR_CLAMP)) ? CUR_CLAMP
                                                      : cur_diff[SAMPLE_W-2:0];
      cur_prod    = 32'(cur_clamped) * CUR_MUL;
      cur_code    = {1'b0, cur_prod[31:CUR_SHIFT]};
   end

   always_comb begin
      result.scaled_voltage = volt_code[8] ? '1 : volt_code[CODE_W-1:0];
      result.scaled_current = cur_code;
      result.over_voltage   = voltage_sample > limits.over_voltage_limit;
      result.under_voltage  = voltage_sample < limits.under_voltage_limit;
      result.over_current   = cur_code > limits.over_current_limit;
   end

endmodule

// ----- src/supply_voltage_current_monitor_core.sv -----
// ============================================================================
// Supply voltage and current monitor
// Current filter, zero-offset calibration and scaled voltage/current report.
// ============================================================================
// The monitor takes one request transaction per clock cycle unless the input
// register is held, and answers update requests through the input register,
// where the filter and calibration state are read and updated, and then
// the response register, where the result waits. Both registers advance
// independently, so a waiting response does not stop filter or calibration
// requests from moving through; only an update request behind an untaken
// response holds the input register. Filter requests fold a current sample
// into f = (3*f + x) >> 2. Calibration requests average 16 current samples
// taken while the offset is unset and the voltage is at or above the
// under-voltage limit; an average of zero leaves the offset unset, and an
// unset offset reads as 512. Update requests return the scaled voltage, the
// scaled current and the three limit flags. Limit registers are written on the
// csr channel, which is always ready, and must only be written while idle.
// ============================================================================
`include "supply_voltage_current_monitor_core_macros.svh"

module supply_voltage_current_monitor_core
   import svcm_pkg::*;
(
   input logic           clock,
   input logic           reset,
   svcm_req_if.sink      req_if,
   svcm_rsp_if.source    rsp_if,
   svcm_csr_if.sink      csr_if
);

   // Input register
   logic                s1_valid_ff, s1_valid_in;
   logic [1:0]          s1_op_ff;
   logic [SAMPLE_W-1:0] s1_cur_ff;
   logic [SAMPLE_W-1:0] s1_volt_ff;
   logic                s1_advance;
   logic                s1_is_update;

   // Monitor state
   limits_type          limits_ff, limits_in;
   logic [SAMPLE_W-1:0] filtered_ff, filtered_in;
   logic [SAMPLE_W-1:0] offset_ff, offset_in;
   logic [CAL_SUM_W-1:0] cal_sum_ff, cal_sum_in;
   logic [CAL_LOG2-1:0]  cal_count_ff, cal_count_in;
   logic [SAMPLE_W+1:0]  filter_acc;
   logic [CAL_SUM_W-1:0] cal_sum_next;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, scale_result;

   // ------------------------------------------------------------------
   // Handshake control
   // ------------------------------------------------------------------
   assign s1_is_update = (s1_op_ff == OP_UPDATE);
   // Advance unless an update result has nowhere to go.
   assign s1_advance   = s1_valid_ff && (!s1_is_update || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign csr_if.ready = 1'b1;

   always_comb begin
      s1_valid_in  = (req_if.valid && req_if.ready) || (s1_valid_ff && !s1_advance);
      rsp_valid_in = (s1_advance && s1_is_update) || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request payload whenever the input register is free.
   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         s1_op_ff   <= req_if.op;
         s1_cur_ff  <= req_if.current_sample;
         s1_volt_ff <= req_if.voltage_sample;
      end
   end

   // ------------------------------------------------------------------
   // Limit registers
   // ------------------------------------------------------------------
   always_comb begin
      limits_in = limits_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_OVER_VOLTAGE:  limits_in.over_voltage_limit  = csr_if.data;
            CSR_UNDER_VOLTAGE: limits_in.under_voltage_limit = csr_if.data;
            CSR_OVER_CURRENT:  limits_in.over_current_limit  = csr_if.data[CODE_W-1:0];
            default:           limits_in = limits_ff;  // drop writes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.over_voltage_limit  <= OVL_RESET;
         limits_ff.under_voltage_limit <= UVL_RESET;
         limits_ff.over_current_limit  <= OCL_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   // ------------------------------------------------------------------
   // Filter and calibration state, updated as a request leaves stage one
   // ------------------------------------------------------------------
   always_comb begin
      filter_acc   = (12'(filtered_ff) * 12'd3) + 12'(s1_cur_ff);
      cal_sum_next = cal_sum_ff + CAL_SUM_W'(s1_cur_ff);

      filtered_in  = filtered_ff;
      offset_in    = offset_ff;
      cal_sum_in   = cal_sum_ff;
      cal_count_in = cal_count_ff;

      if (s1_advance) begin
         unique case (s1_op_ff)
            OP_FILTER: begin
               filtered_in = filter_acc[SAMPLE_W+1:2];
            end
            OP_CALIBRATE: begin
               // Count a sample only while the offset is unset and the supply is up.
               if (offset_ff == OFFSET_UNSET &&
                   s1_volt_ff >= limits_ff.under_voltage_limit) begin
                  if (cal_count_ff == '1) begin
                     offset_in    = cal_sum_next[CAL_SUM_W-1:CAL_LOG2];
                     cal_sum_in   = '0;
                     cal_count_in = '0;
                  end else begin
                     cal_sum_in   = cal_sum_next;
                     cal_count_in = cal_count_ff + 1'b1;
                  end
               end
            end
            default: begin
               // Update reads the state only; the unused code does nothing.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filtered_ff  <= FILTER_RESET;
         offset_ff    <= OFFSET_UNSET;
         cal_sum_ff   <= '0;
         cal_count_ff <= '0;
      end else begin
         filtered_ff  <= filtered_in;
         offset_ff    <= offset_in;
         cal_sum_ff   <= cal_sum_in;
         cal_count_ff <= cal_count_in;
      end
   end

   // ------------------------------------------------------------------
   // Scaling and response register
   // ------------------------------------------------------------------
   svcm_scale u_scale (
      .voltage_sample   (s1_volt_ff),
      .filtered_current (filtered_ff),
      .current_offset   (offset_ff),
      .limits           (limits_ff),
      .result           (scale_result)
   );

   // Load a fresh result only when an update request advances.
   always_ff @(posedge clock) begin
      if (s1_advance && s1_is_update) begin
         rsp_data_ff <= scale_result;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.scaled_voltage = rsp_data_ff.scaled_voltage;
   assign rsp_if.scaled_current = rsp_data_ff.scaled_current;
   assign rsp_if.over_voltage   = rsp_data_ff.over_voltage;
   assign rsp_if.under_voltage  = rsp_data_ff.under_voltage;
   assign rsp_if.over_current   = rsp_data_ff.over_current;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `SVCM_ASSERT_IMPLY(a_cal_only_unset, clock, reset, cal_count_ff != '0, offset_ff == OFFSET_UNSET, "calibration in progress with offset set")
   `SVCM_ASSERT_NEXT(a_update_loads_rsp, clock, reset, s1_advance && s1_is_update, rsp_valid_ff && rsp_data_ff == $past(scale_result), "advanced update did not load response")
   `SVCM_ASSERT_NEXT(a_stall_holds_s1, clock, reset, s1_valid_ff && !s1_advance, s1_valid_ff && $stable(s1_op_ff) && $stable(s1_cur_ff) && $stable(s1_volt_ff), "stalled request changed in stage one")
   `SVCM_ASSERT_IMPLY(a_stall_only_update, clock, reset, s1_valid_ff && !s1_advance, s1_is_update && rsp_valid_ff && !rsp_if.ready, "stage one stalled without a blocked update")

endmodule

// ----- tb/tb.sv -----
// ============================================================================
// Supply monitor testbench
// Drives filter, calibration and update transactions into the monitor core
// with random idling on both channels, predicts every report from its own
// model of the filter, the zero-offset calibration and the scaling, and
// compares each report field by field. The limit registers are changed
// between phases while the core is idle.
// ============================================================================
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import svcm_pkg::*;

   // Op code 3 is not defined; the core must drop it without a trace.
   localparam logic [1:0] OP_UNDEFINED = 2'd3;

   // Cycles to let pass once the last report is in: an input register and a
   // response register, plus margin.
   localparam int DRAIN_CYCLES            = 6;
   localparam int PHASES                  = 6;
   localparam int RANDOM_ITEMS_PER_PHASE  = 66;
   localparam int CALIBRATION_DEPTH       = 16;

   typedef struct {
      logic [1:0]          op;
      logic [SAMPLE_W-1:0] current;
      logic [SAMPLE_W-1:0] voltage;
      bit                  typed;
      result_type          report;
   } stim_row_type;

   logic clock;
   logic reset;

   svcm_req_if req_bus ();
   svcm_rsp_if rsp_bus ();
   svcm_csr_if csr_bus ();

   supply_voltage_current_monitor_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // Predicted state of the core: limits, filter and calibration.
   logic [SAMPLE_W-1:0] ov_limit     = 10'd1000;
   logic [SAMPLE_W-1:0] uv_limit     = 10'd100;
   logic [CODE_W-1:0]   oc_limit     = 8'd200;
   logic [SAMPLE_W-1:0] filter_level = 10'd512;
   logic [SAMPLE_W-1:0] zero_offset  = 10'd0;
   int unsigned         cal_sum      = 0;
   int unsigned         cal_count    = 0;

   result_type pending_reports [$];
   int         failures        = 0;
   int         reports_checked = 0;
   bit         calm            = 1'b0;
   logic [SAMPLE_W-1:0] last_current = 10'd0;

   // Directed transactions. Reports are typed in only where they are plain:
   // right after reset with the voltage at its extremes.
   stim_row_type directed_rows [24] = '{
      '{OP_UPDATE,    10'd0,    10'd0,    1'b1, '{8'd0,   8'd0, 1'b0, 1'b1, 1'b0}},
      '{OP_UPDATE,    10'd1023, 10'd1023, 1'b1, '{8'd255, 8'd0, 1'b1, 1'b0, 1'b0}},
      '{OP_UPDATE,    10'd0,    10'd922,  1'b0, '0},
      '{OP_UPDATE,    10'd0,    10'd99,   1'b0, '0},
      '{OP_UPDATE,    10'd0,    10'd100,  1'b0, '0},
      '{OP_UPDATE,    10'd0,    10'd1000, 1'b0, '0},
      '{OP_UPDATE,    10'd0,    10'd1001, 1'b0, '0},
      '{OP_UPDATE,    10'd0,    10'd600,  1'b0, '0},
      '{OP_FILTER,    10'd1023, 10'd1023, 1'b0, '0},
      '{OP_FILTER,    10'd1023, 10'd0,    1'b0, '0},
      '{OP_FILTER,    10'd1023, 10'd1023, 1'b0, '0},
      '{OP_FILTER,    10'd1023, 10'd0,    1'b0, '0},
      '{OP_FILTER,    10'd1023, 10'd1023, 1'b0, '0},
      '{OP_FILTER,    10'd1023, 10'd0,    1'b0, '0},
      '{OP_UPDATE,    10'd0,    10'd500,  1'b0, '0},
      '{OP_FILTER,    10'd0,    10'd0,    1'b0, '0},
      '{OP_FILTER,    10'd0,    10'd1023, 1'b0, '0},
      '{OP_FILTER,    10'd0,    10'd0,    1'b0, '0},
      '{OP_FILTER,    10'd0,    10'd1023, 1'b0, '0},
      '{OP_FILTER,    10'd0,    10'd0,    1'b0, '0},
      '{OP_UPDATE,    10'd0,    10'd500,  1'b0, '0},
      '{OP_CALIBRATE, 10'd300,  10'd99,   1'b0, '0},
      '{OP_UNDEFINED, 10'd1023, 10'd1023, 1'b0, '0},
      '{OP_UPDATE,    10'd1023, 10'd512,  1'b0, '0}
   };

   // Advance the predicted state by one accepted transaction; return 1 when
   // the transaction produces a report.
   function automatic bit monitor_step(input logic [1:0] op,
                                       input logic [SAMPLE_W-1:0] current,
                                       input logic [SAMPLE_W-1:0] voltage,
                                       output result_type report);
      int unsigned level, volts, offs, delta;
      report = '0;
      case (op)
         OP_FILTER: begin
            level = (int'(filter_level) * 3 + int'(current)) >> 2;
            filter_level = level[SAMPLE_W-1:0];
            return 1'b0;
         end
         OP_CALIBRATE: begin
            // Count only while the offset is unset and the supply is up.
            if (zero_offset == 0 && voltage >= uv_limit) begin
               cal_sum += current;
               cal_count++;
               if (cal_count == CALIBRATION_DEPTH) begin
                  // An average of zero leaves the offset unset.
                  zero_offset = SAMPLE_W'(cal_sum >> 4);
                  cal_sum     = 0;
                  cal_count   = 0;
               end
            end
            return 1'b0;
         end
         OP_UPDATE: begin
            volts = (voltage > 922) ? 922 : voltage;
            volts = ((volts >> 1) * 126 / 3) >> 6;
            if (volts > 255)
               volts = 255;
            offs  = (zero_offset == 0) ? 512 : zero_offset;
            delta = (filter_level >= offs) ? filter_level - offs : offs - filter_level;
            if (delta > 409)
               delta = 409;
            delta = delta * 125 / 427;
            if (delta > 255)
               delta = 255;
            report.scaled_voltage = volts[CODE_W-1:0];
            report.scaled_current = delta[CODE_W-1:0];
            report.over_voltage   = voltage > ov_limit;
            report.under_voltage  = voltage < uv_limit;
            report.over_current   = delta > oc_limit;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Idle length for either side: mostly none or short, now and then long,
   // and none at all during calm stretches.
   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Voltage with a bias toward the extremes and both sides of each limit.
   function automatic logic [SAMPLE_W-1:0] pick_voltage();
      case ($urandom_range(0, 9))
         0: return 10'd0;
         1: return 10'd1023;
         2: return ov_limit + SAMPLE_W'($urandom_range(0, 2)) - 10'd1;
         3: return uv_limit + SAMPLE_W'($urandom_range(0, 2)) - 10'd1;
         default: return SAMPLE_W'($urandom_range(0, 1023));
      endcase
   endfunction

   // Offer one transaction after a random gap, hold it until taken, then
   // record what the core should report for it. Flag undefined items and calibrations once the offset is set.
   task automatic send_item(input logic [1:0] op,
                            input logic [SAMPLE_W-1:0] current,
                            input logic [SAMPLE_W-1:0] voltage,
                            input bit typed,
                            input result_type typed_report,
                            output bit counted);
      int         gap;
      bit         has_report;
      result_type report;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.op             <= op;
      req_bus.current_sample <= current;
      req_bus.voltage_sample <= voltage;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      counted = !(op == OP_UNDEFINED || (op == OP_CALIBRATE && zero_offset != 0));
      has_report = monitor_step(op, current, voltage, report);
      if (has_report)
         pending_reports.push_back(typed ? typed_report : report);
   endtask

   // Wait for the core to go idle, then write all three limit registers
   // back to back and mirror them into the predicted state.
   task automatic program_limits(input logic [SAMPLE_W-1:0] ovl,
                                 input logic [SAMPLE_W-1:0] uvl,
                                 input logic [SAMPLE_W-1:0] ocl);
      logic [SAMPLE_W-1:0] values [3];
      values[0] = ovl;
      values[1] = uvl;
      values[2] = ocl;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      for (int i = 0; i < 3; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= csr_index_type'(i);
         csr_bus.data  <= values[i];
         do @(posedge clock); while (csr_bus.ready !== 1'b1);
         case (csr_index_type'(i))
            CSR_OVER_VOLTAGE:  ov_limit = values[i];
            CSR_UNDER_VOLTAGE: uv_limit = values[i];
            CSR_OVER_CURRENT:  oc_limit = values[i][CODE_W-1:0];
            default: ;
         endcase
      end
      csr_bus.valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Toggle calm stretches, in which neither side idles at random.
   initial begin
      forever begin
         repeat ($urandom_range(150, 400)) @(posedge clock);
         calm <= ~calm;
      end
   end

   // Response side: random back-pressure, plus two long hold-offs so that
   // the response register fills and the core stalls its request channel.
   initial begin : response_sink
      int       gap_left;
      int       hold_left;
      bit [1:0] holds_done;
      gap_left   = 0;
      hold_left  = 0;
      holds_done = 2'b00;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!holds_done[0] && reports_checked >= 30) begin
            holds_done[0] = 1'b1;
            hold_left     = 120;
         end else if (!holds_done[1] && reports_checked >= 160) begin
            holds_done[1] = 1'b1;
            hold_left     = 150;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (gap_left > 0) begin
            rsp_bus.ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            gap_left = pick_gap();
         end
         @(posedge clock);
      end
   end

   // Compare every report the core hands over with the oldest prediction.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = '{rsp_bus.scaled_voltage, rsp_bus.scaled_current, rsp_bus.over_voltage,
                 rsp_bus.under_voltage, rsp_bus.over_current};
         if (pending_reports.size() == 0) begin
            $display("%0t: report with none expected, actual %h", $time, got);
            failures++;
         end else begin
            want = pending_reports.pop_front();
            check_field("scaled_voltage", want.scaled_voltage, got.scaled_voltage);
            check_field("scaled_current", want.scaled_current, got.scaled_current);
            check_field("over_voltage", want.over_voltage, got.over_voltage);
            check_field("under_voltage", want.under_voltage, got.under_voltage);
            check_field("over_current", want.over_current, got.over_current);
         end
         reports_checked++;
      end
   end

   // Stimulus: directed rows under the reset limits, then one random phase
   // per limit setting.
   initial begin : stimulus
      bit                  counted;
      int                  counted_items;
      int                  cal_hits;
      int                  r;
      logic [1:0]          op;
      logic [SAMPLE_W-1:0] current;
      logic [SAMPLE_W-1:0] voltage;
      logic [SAMPLE_W-1:0] ocl;

      req_bus.valid          <= 1'b0;
      req_bus.op             <= OP_FILTER;
      req_bus.current_sample <= '0;
      req_bus.voltage_sample <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.index          <= CSR_OVER_VOLTAGE;
      csr_bus.data           <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].current, directed_rows[i].voltage,
                   directed_rows[i].typed, directed_rows[i].report, counted);
      req_bus.valid <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: program_limits(10'd1000, 10'd100, 10'd200);
            1: program_limits(10'd1023, 10'd0, 10'd0);
            2: program_limits(10'd0, 10'd1023, 10'd1023);
            default: begin
               ocl = ($urandom_range(0, 1) == 0) ? SAMPLE_W'($urandom_range(0, 120))
                                                 : SAMPLE_W'($urandom_range(0, 1023));
               program_limits(SAMPLE_W'($urandom_range(0, 1023)),
                              SAMPLE_W'($urandom_range(0, 400)), ocl);
            end
         endcase

         // A full calibration run of zero current must leave the offset
         // unset; samples under the voltage limit must not count toward it.
         if (phase == 0) begin
            cal_hits = 0;
            while (cal_hits < CALIBRATION_DEPTH) begin
               if ($urandom_range(0, 3) == 0) begin
                  send_item(OP_CALIBRATE, 10'd1023,
                            SAMPLE_W'($urandom_range(0, int'(uv_limit) - 1)),
                            1'b0, '0, counted);
               end else begin
                  send_item(OP_CALIBRATE, 10'd0,
                            SAMPLE_W'($urandom_range(int'(uv_limit), 1023)),
                            1'b0, '0, counted);
                  cal_hits++;
               end
               if ($urandom_range(0, 2) == 0)
                  send_item(OP_UPDATE, SAMPLE_W'($urandom), pick_voltage(), 1'b0, '0,
                            counted);
            end
         end

         counted_items = 0;
         while (counted_items < RANDOM_ITEMS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
               op = OP_FILTER;
               // Repeat the current often so the filter settles at extremes.
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: current = last_current;
                  5:             current = 10'd0;
                  6:             current = 10'd1023;
                  default:       current = SAMPLE_W'($urandom_range(0, 1023));
               endcase
               last_current = current;
               voltage = SAMPLE_W'($urandom);
            end else if (r < 55) begin
               op = OP_CALIBRATE;
               current = ($urandom_range(0, 9) == 0) ? SAMPLE_W'($urandom_range(0, 1023))
                                                     : SAMPLE_W'($urandom_range(0, 255));
               voltage = ($urandom_range(0, 4) != 0)
                            ? SAMPLE_W'($urandom_range(int'(uv_limit), 1023))
                            : pick_voltage();
            end else if (r < 97) begin
               op = OP_UPDATE;
               current = SAMPLE_W'($urandom);
               voltage = pick_voltage();
            end else begin
               op = OP_UNDEFINED;
               current = SAMPLE_W'($urandom);
               voltage = SAMPLE_W'($urandom);
            end
            send_item(op, current, voltage, 1'b0, '0, counted);
            if (counted)
               counted_items++;
         end
         req_bus.valid <= 1'b0;
      end

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   // Drop the run if it hangs; a correct run ends far earlier.
   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

// ----- supply_voltage_current_monitor_core.f -----
+incdir+src
src/svcm_pkg.sv
src/svcm_if.sv
src/svcm_scale.sv
src/supply_voltage_current_monitor_core.sv
tb/tb.sv
